### hdl/mbe_pkg.sv
// mbe_pkg: types, command and status records, register codes and reset
// values shared by the escape-time pixel unit. No dependencies.

package mbe_pkg;

    // Default sizes handed to the top-level parameters
    localparam int DEF_COORD_BITS = 48;
    localparam int DEF_INDEX_BITS = 12;

    // Fixed field widths of a result item
    localparam int OUT_IDX_BITS = 12;
    localparam int ITER_BITS    = 16;
    localparam int SHADE_BITS   = 8;
    localparam logic [ITER_BITS-1:0]  SHADE_LIMIT = 16'd255;
    localparam logic [SHADE_BITS-1:0] SHADE_MAX   = 8'd255;

    // Configuration register codes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RE_MIN   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IM_MAX   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RE_STEP  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IM_STEP  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_ITER = 3'd4;

    // Raw reset values; the low bits are taken at the configured width
    localparam logic signed [63:0] RST_RE_MIN   = -64'sd35184372088832;
    localparam logic signed [63:0] RST_IM_MAX   = 64'sd26388279066624;
    localparam logic [63:0]        RST_RE_STEP  = 64'd41231686041;
    localparam logic [63:0]        RST_IM_STEP  = 64'd73300775185;
    localparam logic [ITER_BITS-1:0] RST_MAX_ITER = 16'd25600;

    // Which product the shared multiplier works on
    typedef enum logic [2:0] {
        SRC_RE,     // re_min + column * re_step
        SRC_IM,     // im_max - row * im_step
        SRC_XX,     // x * x
        SRC_YY,     // y * y
        SRC_XY      // x * y
    } mbe_src_t;

    typedef struct packed {
        logic     in_load;     // take column and row, clear the count
        logic     mul_load;    // load operands, sign and accumulator preset
        mbe_src_t src;
        logic     pp_en;       // form one partial product
        logic [1:0] pp_idx;    // {operand a half, operand b half}
        logic     acc_add;     // fold the previous partial product in
        logic     post;        // finish the product named by src
        logic     out_load;    // write the result register
    } mbe_cmd_t;

    typedef struct packed {
        logic escaped;         // |z|^2 > 4, valid during post of SRC_YY
        logic at_limit;        // count has reached max_iter
        logic out_free;        // result register can take an item
    } mbe_status_t;

endpackage

### hdl/mbe_ctrl.sv
// mbe_ctrl: sequencer for the escape-time pixel unit.
// Depends on mbe_pkg; drives mbe_datapath through mbe_cmd_t.

module mbe_ctrl
    import mbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  mbe_status_t status,
    output mbe_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_POST,
        ST_CHECK,
        ST_DONE
    } state_t;

    state_t     state_reg, state_next;
    mbe_src_t   phase_reg, phase_next;
    logic [2:0] k_reg, k_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.src    = phase_reg;
        cmd.pp_idx = k_reg[1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    phase_next  = SRC_RE;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.mul_load = 1'b1;
                k_next       = 3'd0;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                // four partial products, each folded in on the following cycle
                cmd.pp_en   = ~k_reg[2];
                cmd.acc_add = (k_reg != 3'd0);
                k_next      = k_reg + 3'd1;
                if (k_reg[2])
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                cmd.post = 1'b1;
                case (phase_reg)
                    SRC_RE:
                    begin
                        phase_next = SRC_IM;
                        state_next = ST_LOAD;
                    end
                    SRC_IM:
                    begin
                        state_next = ST_CHECK;
                    end
                    SRC_XX:
                    begin
                        phase_next = SRC_YY;
                        state_next = ST_LOAD;
                    end
                    SRC_YY:
                    begin
                        if (status.escaped)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            phase_next = SRC_XY;
                            state_next = ST_LOAD;
                        end
                    end
                    SRC_XY:
                    begin
                        state_next = ST_CHECK;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_CHECK:
            begin
                if (status.at_limit)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    phase_next = SRC_XX;
                    state_next = ST_LOAD;
                end
            end
            ST_DONE:
            begin
                // hold until the result register is free
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= SRC_RE;
            k_reg     <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            k_reg     <= k_next;
        end
    end

endmodule

### hdl/mbe_datapath.sv
// mbe_datapath: configuration registers, shared partial-product multiplier,
// accumulator, iterate registers and the result register.
// Depends on mbe_pkg; sequenced by mbe_ctrl.

module mbe_datapath
    import mbe_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int INDEX_BITS = DEF_INDEX_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  mbe_cmd_t                  cmd,
    output mbe_status_t               status,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]     cfg_data,
    input  logic [INDEX_BITS-1:0]     column,
    input  logic [INDEX_BITS-1:0]     row,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [OUT_IDX_BITS-1:0]   pixel_column,
    output logic [OUT_IDX_BITS-1:0]   pixel_row,
    output logic [ITER_BITS-1:0]      iterations,
    output logic                      inside_res,
    output logic [SHADE_BITS-1:0]     shade
);

    localparam int W = COORD_BITS;
    localparam int F = W - 4;            // fraction bits
    localparam int H = (W + 1) / 2;      // multiplier half width
    localparam int M = 2 * H;            // operand width
    localparam int P = 2 * W + 2;        // accumulator width
    localparam logic [P-1:0] FOUR_Q = P'(1) << (2 * F + 2);

    // Configuration
    logic signed [W-1:0]   re_min_reg, im_max_reg;
    logic [W-2:0]          re_step_reg, im_step_reg;
    logic [ITER_BITS-1:0]  max_iter_reg;

    // Item and iterate state
    logic [INDEX_BITS-1:0] col_reg, row_reg;
    logic [ITER_BITS-1:0]  count_reg;
    logic signed [W-1:0]   cre_reg, cim_reg, x_reg, y_reg;

    // Multiplier and accumulator
    logic [M-1:0]          opa_reg, opb_reg, pp_reg;
    logic [1:0]            sh_reg;
    logic                  sub_reg;
    logic signed [P-1:0]   acc_reg, t_reg;

    logic                  out_valid_reg;
    logic [OUT_IDX_BITS-1:0] out_col_reg, out_row_reg;
    logic [ITER_BITS-1:0]  out_iter_reg;
    logic                  out_inside_reg;
    logic [SHADE_BITS-1:0] out_shade_reg;

    function automatic logic [M-1:0] mag(input logic signed [W-1:0] v);
        logic [W-1:0] u;
        u = v[W-1] ? (~v + 1'b1) : v;
        return M'(u);
    endfunction

    function automatic logic signed [W-1:0] sat(input logic signed [P-1:0] v);
        logic signed [W-1:0] r;
        if ((&v[P-1:W-1]) || ~(|v[P-1:W-1]))
        begin
            r = v[W-1:0];
        end
        else if (v[P-1])
        begin
            r = {1'b1, {(W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(W-1){1'b1}}};
        end
        return r;
    endfunction

    // Operand select for a new product
    logic [M-1:0]        opa_sel, opb_sel;
    logic                sub_sel;
    logic signed [P-1:0] preset_sel;

    always_comb
    begin
        opa_sel    = '0;
        opb_sel    = '0;
        sub_sel    = 1'b0;
        preset_sel = '0;
        case (cmd.src)
            SRC_RE:
            begin
                opa_sel    = M'(col_reg);
                opb_sel    = M'(re_step_reg);
                preset_sel = P'(re_min_reg);
            end
            SRC_IM:
            begin
                opa_sel    = M'(row_reg);
                opb_sel    = M'(im_step_reg);
                sub_sel    = 1'b1;
                preset_sel = P'(im_max_reg);
            end
            SRC_XX:
            begin
                opa_sel = mag(x_reg);
                opb_sel = mag(x_reg);
            end
            SRC_YY:
            begin
                opa_sel = mag(y_reg);
                opb_sel = mag(y_reg);
            end
            SRC_XY:
            begin
                opa_sel = mag(x_reg);
                opb_sel = mag(y_reg);
                sub_sel = x_reg[W-1] ^ y_reg[W-1];
            end
            default:
            begin
                opa_sel = '0;
            end
        endcase
    end

    // One H x H partial product per cycle
    logic [H-1:0] a_part, b_part;
    logic [M-1:0] pp_next;

    assign a_part  = cmd.pp_idx[1] ? opa_reg[M-1:H] : opa_reg[H-1:0];
    assign b_part  = cmd.pp_idx[0] ? opb_reg[M-1:H] : opb_reg[H-1:0];
    assign pp_next = M'(a_part) * M'(b_part);

    logic [P-1:0]        pp_wide;
    logic signed [P-1:0] pp_shifted;

    assign pp_wide = P'(pp_reg);

    always_comb
    begin
        case (sh_reg)
            2'd0:    pp_shifted = pp_wide;
            2'd1:    pp_shifted = pp_wide << H;
            2'd2:    pp_shifted = pp_wide << (2 * H);
            default: pp_shifted = '0;
        endcase
    end

    // Post-processing of a finished product
    logic [P-1:0]        mag_sum;
    logic signed [P-1:0] re_sum, im_sum;

    assign mag_sum = t_reg + acc_reg;
    assign re_sum  = (t_reg >>> F) + P'(cre_reg);
    assign im_sum  = (acc_reg >>> (F - 1)) + P'(cim_reg);   // 2xy, then floor

    assign status.escaped  = (mag_sum > FOUR_Q);
    assign status.at_limit = ~(count_reg < max_iter_reg);
    assign status.out_free = ~out_valid_reg | out_ready;

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            re_min_reg    <= RST_RE_MIN[W-1:0];
            im_max_reg    <= RST_IM_MAX[W-1:0];
            re_step_reg   <= RST_RE_STEP[W-2:0];
            im_step_reg   <= RST_IM_STEP[W-2:0];
            max_iter_reg  <= RST_MAX_ITER;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RE_MIN:   re_min_reg   <= cfg_data[W-1:0];
                    CFG_IM_MAX:   im_max_reg   <= cfg_data[W-1:0];
                    CFG_RE_STEP:  re_step_reg  <= cfg_data[W-2:0];
                    CFG_IM_STEP:  im_step_reg  <= cfg_data[W-2:0];
                    CFG_MAX_ITER: max_iter_reg <= cfg_data[ITER_BITS-1:0];
                    default:      ;
                endcase
            end

            if (cmd.in_load)
            begin
                count_reg <= '0;
            end
            else if (cmd.post && (cmd.src == SRC_XY))
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            col_reg <= column;
            row_reg <= row;
        end

        if (cmd.mul_load)
        begin
            opa_reg <= opa_sel;
            opb_reg <= opb_sel;
            sub_reg <= sub_sel;
            acc_reg <= preset_sel;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= sub_reg ? (acc_reg - pp_shifted) : (acc_reg + pp_shifted);
        end

        if (cmd.pp_en)
        begin
            pp_reg <= pp_next;
            sh_reg <= {1'b0, cmd.pp_idx[1]} + {1'b0, cmd.pp_idx[0]};
        end

        if (cmd.post)
        begin
            case (cmd.src)
                SRC_RE:
                begin
                    cre_reg <= sat(acc_reg);
                    x_reg   <= sat(acc_reg);
                end
                SRC_IM:
                begin
                    cim_reg <= sat(acc_reg);
                    y_reg   <= sat(acc_reg);
                end
                SRC_XX:
                begin
                    t_reg <= acc_reg;
                end
                SRC_YY:
                begin
                    t_reg <= t_reg - acc_reg;   // xx - yy
                end
                SRC_XY:
                begin
                    x_reg <= sat(re_sum);
                    y_reg <= sat(im_sum);
                end
                default:
                begin
                    t_reg <= t_reg;
                end
            endcase
        end

        if (cmd.out_load)
        begin
            out_col_reg    <= OUT_IDX_BITS'(col_reg);
            out_row_reg    <= OUT_IDX_BITS'(row_reg);
            out_iter_reg   <= count_reg;
            out_inside_reg <= (count_reg == max_iter_reg);
            if (count_reg == max_iter_reg)
            begin
                out_shade_reg <= '0;
            end
            else if (count_reg < SHADE_LIMIT)
            begin
                out_shade_reg <= count_reg[SHADE_BITS-1:0];
            end
            else
            begin
                out_shade_reg <= SHADE_MAX;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_column = out_col_reg;
    assign pixel_row    = out_row_reg;
    assign iterations   = out_iter_reg;
    assign inside_res   = out_inside_reg;
    assign shade        = out_shade_reg;

endmodule

### hdl/mandelbrot_escape_time_pixel.sv
// mandelbrot_escape_time_pixel: top level of the escape-time pixel unit.
// Depends on mbe_pkg, mbe_ctrl and mbe_datapath.
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   s_tdata: column, row
//  m_*       out  m_tvalid/m_tready   m_tdata: pixel_column, pixel_row,
//                                     iterations, shade; m_tuser: inside_res
//  cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item at a time. After the accept the pixel is mapped to c with two
// products; each iteration then forms three 48-bit products (each four partial
// products through one shared multiplier plus load and finish); an iteration
// that escapes stops after y * y.
// The result register frees the input side: a new item is taken while a
// result waits; a stalled result stalls only the next item's hand-over.
// Reset loads the register defaults; cfg_ready is always high.

module mandelbrot_escape_time_pixel
    import mbe_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int INDEX_BITS = DEF_INDEX_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // column [INDEX_BITS-1:0], row [2*INDEX_BITS-1:INDEX_BITS], zero padding
    input  logic [((2*INDEX_BITS+7)/8)*8-1:0] s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // pixel_column [11:0], pixel_row [23:12], iterations [39:24], shade [47:40]
    output logic [47:0]               m_tdata,
    // inside_res [0]
    output logic                      m_tuser,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]     cfg_data
);

    mbe_cmd_t    cmd;
    mbe_status_t status;

    logic [OUT_IDX_BITS-1:0] pixel_column, pixel_row;
    logic [ITER_BITS-1:0]    iterations;
    logic [SHADE_BITS-1:0]   shade;

    assign cfg_ready = 1'b1;

    mbe_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mbe_datapath
    #(
        .COORD_BITS (COORD_BITS),
        .INDEX_BITS (INDEX_BITS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_valid & cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .column       (s_tdata[INDEX_BITS-1:0]),
        .row          (s_tdata[2*INDEX_BITS-1:INDEX_BITS]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .iterations   (iterations),
        .inside_res   (m_tuser),
        .shade        (shade)
    );

    assign m_tdata = {shade, iterations, pixel_row, pixel_column};

    // Busy after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in progress");

    // A pixel inside the set is drawn black
    a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> shade == '0)
        else $error("inside pixel with non-zero shade");

    // Below the clamp the shade follows the count
    a_shade_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser && (iterations < SHADE_LIMIT)
        |-> shade == iterations[SHADE_BITS-1:0])
        else $error("shade does not match iteration count");

endmodule

### tb/tb_mandelbrot_escape_time_pixel.sv
`timescale 1ns / 100ps
// Self-checking testbench for the escape-time pixel unit: drives pixel items,
// predicts iteration count, inside flag and shade, checks every result item.
// Depends on mbe_pkg and mandelbrot_escape_time_pixel.

module tb_mandelbrot_escape_time_pixel;
    import mbe_pkg::*;

    localparam int COORD_W = DEF_COORD_BITS;
    localparam int FRAC_W  = COORD_W - 4;
    localparam int IDX_W   = DEF_INDEX_BITS;
    localparam int DATA_W  = ((2 * IDX_W + 7) / 8) * 8;

    typedef logic signed [127:0] wide_t;
    localparam wide_t COORD_HI  = (wide_t'(1) <<< (COORD_W - 1)) - 1;
    localparam wide_t COORD_LO  = -(wide_t'(1) <<< (COORD_W - 1));
    localparam wide_t ESCAPE_R2 = wide_t'(1) <<< (2 * FRAC_W + 2);
    localparam logic [63:0] Q_ONE = 64'd1 << FRAC_W;

    typedef enum int {VIEW_WIDE, VIEW_ZOOM, VIEW_RAW} view_kind_t;

    typedef struct packed {
        logic [OUT_IDX_BITS-1:0] column;
        logic [OUT_IDX_BITS-1:0] row;
        logic [ITER_BITS-1:0]    iterations;
        logic                    inside_flag;
        logic [SHADE_BITS-1:0]   shade;
    } pixel_t;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [DATA_W-1:0]         s_tdata;    // column [11:0], row [23:12]
    logic                      m_tvalid;
    logic                      m_tready;
    logic [47:0]               m_tdata;    // column, row, iterations, shade
    logic                      m_tuser;    // inside_res [0]
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [COORD_W-1:0]        cfg_data;

    // Register copies used by the escape predictor
    logic signed [COORD_W-1:0] re_left;
    logic signed [COORD_W-1:0] im_top;
    logic [COORD_W-2:0]        re_pitch;
    logic [COORD_W-2:0]        im_pitch;
    logic [ITER_BITS-1:0]      iter_limit;

    pixel_t pixels_due[$];
    int     mismatch_count;
    int     pixels_sent;
    int     results_seen;
    int     inside_seen;
    int     shade_capped;
    int     settings_used;
    bit     idle_on;
    int     hold_cycles;

    mandelbrot_escape_time_pixel uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(input wide_t v);
        if (v > COORD_HI)
            return COORD_HI[COORD_W-1:0];
        if (v < COORD_LO)
            return COORD_LO[COORD_W-1:0];
        return v[COORD_W-1:0];
    endfunction

    function automatic pixel_t escape_pixel(input logic [IDX_W-1:0] col,
                                            input logic [IDX_W-1:0] row);
        wide_t col_w, row_w, step_re, step_im, xx, yy, xy, mag, diff;
        logic signed [COORD_W-1:0] c_re, c_im, x, y;
        int unsigned n;
        logic escaped;
        pixel_t r;
        col_w = '0;
        col_w[IDX_W-1:0] = col;
        row_w = '0;
        row_w[IDX_W-1:0] = row;
        step_re = '0;
        step_re[COORD_W-2:0] = re_pitch;
        step_im = '0;
        step_im[COORD_W-2:0] = im_pitch;
        c_re = clamp_coord(re_left + col_w * step_re);
        c_im = clamp_coord(im_top - row_w * step_im);
        x = c_re;
        y = c_im;
        n = 0;
        escaped = 1'b0;
        while (!escaped && n < iter_limit)
        begin
            xx = x * x;
            yy = y * y;
            mag = xx + yy;
            if (mag > ESCAPE_R2)
                escaped = 1'b1;
            else
            begin
                xy = x * y;
                xy = xy + xy;
                // floor to the coordinate grid, then add c and clamp
                diff = (xx - yy) >>> FRAC_W;
                xy = xy >>> FRAC_W;
                x = clamp_coord(diff + c_re);
                y = clamp_coord(xy + c_im);
                n++;
            end
        end
        r.column = col;
        r.row = row;
        r.iterations = n[ITER_BITS-1:0];
        r.inside_flag = (n == iter_limit);
        r.shade = r.inside_flag ? '0 : (n < 255 ? n[7:0] : SHADE_MAX);
        return r;
    endfunction

    // Result side: random stalls, plus a long hold-off when asked for
    initial
    begin
        int burst;
        burst = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else if (burst > 0)
            begin
                burst--;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 15) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic check_field(input pixel_t want, input string name,
                               input int unsigned expv, input int unsigned gotv);
        if (expv != gotv)
        begin
            $display("%0t ns: pixel (%0d,%0d) %s expected %0d, got %0d",
                     $time, want.column, want.row, name, expv, gotv);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        pixel_t seen, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.column = m_tdata[11:0];
            seen.row = m_tdata[23:12];
            seen.iterations = m_tdata[39:24];
            seen.shade = m_tdata[47:40];
            seen.inside_flag = m_tuser;
            if (pixels_due.size() == 0)
            begin
                $display("%0t ns: result for pixel (%0d,%0d) with no item pending",
                         $time, seen.column, seen.row);
                mismatch_count++;
            end
            else
            begin
                want = pixels_due.pop_front();
                check_field(want, "column", 32'(want.column), 32'(seen.column));
                check_field(want, "row", 32'(want.row), 32'(seen.row));
                check_field(want, "iterations", 32'(want.iterations),
                            32'(seen.iterations));
                check_field(want, "inside", 32'(want.inside_flag),
                            32'(seen.inside_flag));
                check_field(want, "shade", 32'(want.shade), 32'(seen.shade));
                results_seen++;
                if (want.inside_flag)
                    inside_seen++;
                if (want.shade == SHADE_MAX)
                    shade_capped++;
            end
        end
    end

    task automatic send_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {row, col};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pixels_due.push_back(escape_pixel(col, row));
        pixels_sent++;
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_pixel(IDX_W'($urandom_range(0, 4095)), IDX_W'($urandom_range(0, 4095)));
    endtask

    // Drop valid, let every pending result drain, then let the pipe settle
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [COORD_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_RE_MIN:   re_left = value;
            CFG_IM_MAX:   im_top = value;
            CFG_RE_STEP:  re_pitch = value[COORD_W-2:0];
            CFG_IM_STEP:  im_pitch = value[COORD_W-2:0];
            CFG_MAX_ITER: iter_limit = value[ITER_BITS-1:0];
            default:      ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_view(input logic [COORD_W-1:0] re0, input logic [COORD_W-1:0] im0,
                            input logic [COORD_W-1:0] dre, input logic [COORD_W-1:0] dim,
                            input logic [COORD_W-1:0] limit);
        wait_idle();
        write_reg(CFG_RE_MIN, re0);
        write_reg(CFG_IM_MAX, im0);
        write_reg(CFG_RE_STEP, dre);
        write_reg(CFG_IM_STEP, dim);
        write_reg(CFG_MAX_ITER, limit);
        settings_used++;
    endtask

    // Reset view: corners all escape at once, both corners in row 4095 saturate
    task automatic test_reset_defaults();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
    endtask

    task automatic test_register_extremes();
        // zero limit: no iteration, reported as inside
        set_view('0, '0, '0, '0, '0);
        send_pixel(12'd4095, 12'd4095);
        // origin with a limit of one
        set_view('0, '0, '0, '0, 48'd1);
        send_pixel(12'd0, 12'd0);
        // largest corner, widest steps, full limit: start point saturates
        set_view(COORD_HI[COORD_W-1:0], COORD_LO[COORD_W-1:0], '1, '1, '1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd4095);
        set_view(COORD_LO[COORD_W-1:0], COORD_HI[COORD_W-1:0], '1, '1, '1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
    endtask

    // |z|^2 exactly 4 does not escape
    task automatic test_escape_boundary();
        set_view(48'(2 * Q_ONE), '0, '0, '0, 48'd5);
        send_pixel(12'd7, 12'd9);
        set_view(48'(-2 * Q_ONE), '0, '0, '0, 48'd5);
        send_pixel(12'd4000, 12'd12);
    endtask

    task automatic test_unknown_index();
        wait_idle();
        for (int i = CFG_MAX_ITER + 1; i < (1 << CFG_INDEX_BITS); i++)
            write_reg(CFG_INDEX_BITS'(i), COORD_W'(rnd64()));
        send_pixel(12'd1, 12'd2);
    endtask

    // Near the neck at -0.75, escape takes a few hundred steps
    task automatic test_shade_cap();
        set_view(48'(-64'sd13194139533312), 48'd219902325555, '0, 48'd16777216, 48'd600);
        send_random(10);
    endtask

    task automatic test_backpressure();
        set_view(48'(-2 * Q_ONE), 48'(Q_ONE + Q_ONE / 2), 48'd12884901888, 48'd12884901888,
                 48'd4);
        hold_cycles = 3000;
        send_random(6);
    endtask

    task automatic test_random_views(input int rounds, input int per_round);
        view_kind_t kind;
        logic [63:0] re0, im0, dre, dim;
        logic [15:0] limit;
        for (int k = 0; k < rounds; k++)
        begin
            kind = view_kind_t'(k % 3);
            case (kind)
                VIEW_WIDE:
                begin
                    re0 = -2 * Q_ONE + rnd64() % (Q_ONE / 2);
                    im0 = Q_ONE + rnd64() % Q_ONE;
                    dre = 64'd12884901888 + $urandom_range(0, 32'h7FFF_FFFF);
                    dim = 64'd12884901888 + $urandom_range(0, 32'h7FFF_FFFF);
                    limit = 16'($urandom_range(1, 40));
                end
                VIEW_ZOOM:
                begin
                    re0 = -2 * Q_ONE + rnd64() % (5 * Q_ONE / 2);
                    im0 = -Q_ONE + rnd64() % (2 * Q_ONE);
                    dre = 64'($urandom_range(0, 1 << 28));
                    dim = 64'($urandom_range(0, 1 << 28));
                    limit = 16'($urandom_range(1, 48));
                end
                default:
                begin
                    re0 = rnd64();
                    im0 = rnd64();
                    dre = rnd64();
                    dim = rnd64();
                    limit = 16'($urandom_range(1, 64));
                end
            endcase
            // step bit above the register width is ignored
            dre[COORD_W-1] = 1'($urandom_range(0, 1));
            dim[COORD_W-1] = 1'($urandom_range(0, 1));
            set_view(re0[COORD_W-1:0], im0[COORD_W-1:0], dre[COORD_W-1:0],
                     dim[COORD_W-1:0], COORD_W'({rnd64() >> 16, limit}));
            // hold both sides busy for the closing round
            if (k == rounds - 1)
                idle_on = 1'b0;
            send_random(per_round);
        end
    endtask

    initial
    begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        idle_on = 1'b1;
        hold_cycles = 0;
        mismatch_count = 0;
        pixels_sent = 0;
        results_seen = 0;
        inside_seen = 0;
        shade_capped = 0;
        settings_used = 1;
        re_left = RST_RE_MIN[COORD_W-1:0];
        im_top = RST_IM_MAX[COORD_W-1:0];
        re_pitch = RST_RE_STEP[COORD_W-2:0];
        im_pitch = RST_IM_STEP[COORD_W-2:0];
        iter_limit = RST_MAX_ITER;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_escape_boundary();
        test_unknown_index();
        test_shade_cap();
        test_backpressure();
        test_random_views(8, 250);
        wait_idle();

        $display("Sent %0d pixels under %0d register settings, checked %0d results",
                 pixels_sent, settings_used, results_seen);
        $display("%0d results inside the set, %0d with the shade at its ceiling",
                 inside_seen, shade_capped);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #150_000_000;
        $display("Timed out with %0d results pending", pixels_due.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
hdl/mbe_pkg.sv
hdl/mbe_ctrl.sv
hdl/mbe_datapath.sv
hdl/mandelbrot_escape_time_pixel.sv
tb/tb_mandelbrot_escape_time_pixel.sv
